// File: hdl/assert_macros.svh
// Assertion helpers for the RTL files; included by the top-level file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset only.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/rgv_pkg.sv
// ----------------------------------------------------------------------------
// rgv_pkg
// Types, constants and helpers for the voxel grid traversal block.
// ----------------------------------------------------------------------------
package rgv_pkg;

  localparam logic signed [31:0] T_HI = 32'sh7fffffff;
  localparam logic signed [31:0] T_LO = 32'sh80000000;

  // divider operand widths: dividend up to (p - lo) * n, divisor up to hi - lo
  localparam int DIV_NW = 58;
  localparam int DIV_VW = 34;

  localparam logic [1:0] AX_LAST = 2'd2;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5,
    REG_GRID_DIMS = 3'd6
  } rgv_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLAB,
    S_SLAB_W,
    S_MINMAX,
    S_CHECK,
    S_INC,
    S_INC_W,
    S_MUL,
    S_CELL,
    S_CELL_W,
    S_BND,
    S_WALK
  } rgv_state_e;

  typedef struct packed {
    logic       load;
    logic       slab_start;
    logic       slab_wr;
    logic       tload;
    logic       inc_start;
    logic       inc_wr;
    logic       mul;
    logic       cell_start;
    logic       cell_wr;
    logic       cell_zero;
    logic       bnd_wr;
    logic       emit_miss;
    logic       walk;
    logic       side;
    logic [1:0] axis;
  } rgv_cmd_t;

  typedef struct packed {
    logic dz;
    logic wpos;
    logic div_done;
    logic miss;
    logic out_free;
    logic walk_last;
  } rgv_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return T_HI;
    end else if (v < -64'sd2147483648) begin
      return T_LO;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: hdl/rgv_div.sv
// ----------------------------------------------------------------------------
// rgv_div
// Signed restoring divider, one quotient bit per cycle, truncating quotient.
// ----------------------------------------------------------------------------
module rgv_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [rgv_pkg::DIV_NW-1:0] num_i,
  input  logic signed [rgv_pkg::DIV_VW-1:0] den_i,
  output logic                             done_o,
  output logic signed [rgv_pkg::DIV_NW-1:0] quot_o,
  output logic                             rem_nz_o
);

  localparam int NW = rgv_pkg::DIV_NW;
  localparam int VW = rgv_pkg::DIV_VW;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [VW:0]   rem_q;
  logic [VW-1:0] den_q;
  logic          neg_q;

  logic [NW-1:0] num_mag;
  logic [VW-1:0] den_mag;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;

  assign num_mag = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag = den_i[VW-1] ? (~den_i + 1'b1) : den_i;
  assign rem_sh  = {rem_q[VW-1:0], num_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_mag;
      den_q <= den_mag;
      rem_q <= '0;
      neg_q <= num_i[NW-1] ^ den_i[VW-1];
    end else if (busy_q) begin
      if (!rem_sub[VW]) begin
        rem_q <= rem_sub;
        num_q <= {num_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[NW-2:0], 1'b0};
      end
    end
  end

  assign done_o   = done_q;
  assign quot_o   = neg_q ? (~num_q + 1'b1) : num_q;
  assign rem_nz_o = |rem_q;

endmodule

// File: hdl/rgv_dp.sv
// ----------------------------------------------------------------------------
// rgv_dp
// Datapath: config registers, slab and setup arithmetic, cell walk, output word.
// ----------------------------------------------------------------------------
module rgv_dp #(
  parameter int AXIS_CELLS_MAX = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic signed [31:0]  org_x_i,
  input  logic signed [31:0]  org_y_i,
  input  logic signed [31:0]  org_z_i,
  input  logic signed [31:0]  dir_x_i,
  input  logic signed [31:0]  dir_y_i,
  input  logic signed [31:0]  dir_z_i,
  input  rgv_pkg::rgv_cmd_t   cmd_i,
  output rgv_pkg::rgv_stat_t  stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                missed_o,
  output logic [11:0]         cell_index_o,
  output logic [3:0]          cell_x_o,
  output logic [3:0]          cell_y_o,
  output logic [3:0]          cell_z_o,
  output logic signed [31:0]  t_exit_o,
  output logic                last_o
);

  localparam int         CNT_W  = $clog2(3 * AXIS_CELLS_MAX);
  localparam logic [CNT_W:0] LIMIT = (CNT_W + 1)'(3 * AXIS_CELLS_MAX - 2);
  localparam logic [4:0] NCAP   = 5'((AXIS_CELLS_MAX > 16) ? 16 : AXIS_CELLS_MAX);

  localparam int NW = rgv_pkg::DIV_NW;
  localparam int VW = rgv_pkg::DIV_VW;

  logic signed [31:0] lo_q [3];
  logic signed [31:0] hi_q [3];
  logic [11:0]        dims_q;

  logic signed [31:0] o_q [3];
  logic signed [31:0] d_q [3];
  logic signed [31:0] tmin_q [3];
  logic signed [31:0] tmax_q [3];
  logic signed [31:0] inc_q [3];
  logic signed [31:0] nb_q [3];
  logic [3:0]         coord_q [3];
  logic               down_q [3];
  logic signed [31:0] t0_q, t1_q;
  logic signed [31:0] t0_w, t1_w;
  logic signed [63:0] prod_q;
  logic [CNT_W-1:0]   cnt_q;

  logic               out_valid_q, missed_q, last_q;
  logic [11:0]        idx_q;
  logic [3:0]         cx_q, cy_q, cz_q;
  logic signed [31:0] texit_q;

  logic [4:0]         n_w [3];

  // divider
  logic                 div_start, div_done, div_rnz;
  logic signed [NW-1:0] div_num, div_q;
  logic signed [VW-1:0] div_den;

  // per-axis selection
  logic [1:0]         sel;
  logic signed [31:0] o_s, d_s, lo_s, hi_s, tmin_s, tmax_s, inc_s, bound;
  logic [4:0]         n_s;
  logic [3:0]         c_s;
  logic               dz, in_rng, org_in, dpos;
  logic signed [63:0] slab_num, inc_num, p64, cell_num, w64, cell_f, mult64, bsum;
  logic signed [31:0] slab_sat, slab_v0, slab_v1;

  // walk
  logic [1:0]         ax;
  logic signed [31:0] nb_ax;
  logic               leave, walk_last, out_free;
  logic [15:0]        idx_w;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      n_w[a] = ({1'b0, dims_q[4*a +: 4]} + 5'd1 > NCAP) ? NCAP
             : ({1'b0, dims_q[4*a +: 4]} + 5'd1);
    end
  end

  always_comb begin
    sel    = cmd_i.axis;
    o_s    = o_q[sel];
    d_s    = d_q[sel];
    lo_s   = lo_q[sel];
    hi_s   = hi_q[sel];
    tmin_s = tmin_q[sel];
    tmax_s = tmax_q[sel];
    inc_s  = inc_q[sel];
    n_s    = n_w[sel];
    c_s    = coord_q[sel];
    dz     = (d_s == 32'sd0);
    dpos   = (d_s > 32'sd0);
    in_rng = (lo_s <= o_s) && (o_s <= hi_s);
    org_in = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (!((lo_q[a] < o_q[a]) && (o_q[a] < hi_q[a]))) org_in = 1'b0;
    end
    bound    = cmd_i.side ? hi_s : lo_s;
    slab_num = (64'(bound) - 64'(o_s)) <<< 16;
    inc_num  = 64'(tmax_s) - 64'(tmin_s);
    p64      = org_in ? 64'(o_s) : 64'(o_s) + (prod_q >>> 16);
    cell_num = (p64 - 64'(lo_s)) * $signed({59'd0, n_s});
    w64      = 64'(hi_s) - 64'(lo_s);

    slab_sat = rgv_pkg::sat32(64'(div_q));
    slab_v0  = dz ? (in_rng ? rgv_pkg::T_LO : rgv_pkg::T_HI) : slab_sat;
    slab_v1  = dz ? (in_rng ? rgv_pkg::T_HI : rgv_pkg::T_LO) : slab_sat;

    // floor of the cell quotient, then clamp into the grid
    cell_f = 64'(div_q) - ((div_rnz && cell_num < 0) ? 64'sd1 : 64'sd0);

    mult64 = (dpos ? ($signed({59'd0, c_s, 1'b0} >> 1) + 64'sd1)
                   : ($signed({59'd0, n_s}) - $signed({60'd0, c_s})));
    bsum   = 64'(tmin_s) + mult64 * 64'(inc_s);

    // largest entry and smallest exit over the three slabs
    t0_w = (tmin_q[0] > tmin_q[1]) ? tmin_q[0] : tmin_q[1];
    if (tmin_q[2] > t0_w) t0_w = tmin_q[2];
    t1_w = (tmax_q[0] < tmax_q[1]) ? tmax_q[0] : tmax_q[1];
    if (tmax_q[2] < t1_w) t1_w = tmax_q[2];
  end

  always_comb begin
    div_start = cmd_i.slab_start || cmd_i.inc_start || cmd_i.cell_start;
    if (cmd_i.slab_start) begin
      div_num = slab_num[NW-1:0];
      div_den = VW'(d_s);
    end else if (cmd_i.inc_start) begin
      div_num = inc_num[NW-1:0];
      div_den = {{(VW-5){1'b0}}, n_s};
    end else begin
      div_num = cell_num[NW-1:0];
      div_den = w64[VW-1:0];
    end
  end

  rgv_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .done_o   (div_done),
    .quot_o   (div_q),
    .rem_nz_o (div_rnz)
  );

  // walk: x only on a strict minimum, then y below z, else z
  always_comb begin
    if (nb_q[0] < nb_q[1] && nb_q[0] < nb_q[2]) begin
      ax = 2'd0;
    end else if (nb_q[1] < nb_q[2]) begin
      ax = 2'd1;
    end else begin
      ax = 2'd2;
    end
    nb_ax     = nb_q[ax];
    leave     = down_q[ax] ? (coord_q[ax] == 4'd0)
                           : ({1'b0, coord_q[ax]} + 5'd1 >= n_w[ax]);
    walk_last = leave || ({1'b0, cnt_q} + 1'b1 >= LIMIT);
    idx_w     = 16'(coord_q[0]) + 16'(n_w[0]) * 16'(coord_q[1])
              + 16'(n_w[0]) * 16'(n_w[1]) * 16'(coord_q[2]);
    out_free  = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= 32'sd0;
        hi_q[a] <= 32'sd65536;
      end
      dims_q <= '0;
    end else if (cfg_valid_i) begin
      case (rgv_pkg::rgv_reg_e'(cfg_index_i))
        rgv_pkg::REG_BOX_MIN_X: lo_q[0] <= cfg_data_i;
        rgv_pkg::REG_BOX_MIN_Y: lo_q[1] <= cfg_data_i;
        rgv_pkg::REG_BOX_MIN_Z: lo_q[2] <= cfg_data_i;
        rgv_pkg::REG_BOX_MAX_X: hi_q[0] <= cfg_data_i;
        rgv_pkg::REG_BOX_MAX_Y: hi_q[1] <= cfg_data_i;
        rgv_pkg::REG_BOX_MAX_Z: hi_q[2] <= cfg_data_i;
        rgv_pkg::REG_GRID_DIMS: dims_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        coord_q[a] <= '0;
        nb_q[a]    <= '0;
        inc_q[a]   <= '0;
        down_q[a]  <= 1'b0;
      end
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) cnt_q <= '0;
      if (cmd_i.inc_wr) inc_q[sel] <= rgv_pkg::sat32(64'(div_q));
      if (cmd_i.cell_wr) begin
        if (cmd_i.cell_zero || cell_f < 0) begin
          coord_q[sel] <= 4'd0;
        end else if (cell_f > $signed({59'd0, n_s}) - 64'sd1) begin
          coord_q[sel] <= 4'(n_s - 5'd1);
        end else begin
          coord_q[sel] <= cell_f[3:0];
        end
      end
      if (cmd_i.bnd_wr) begin
        nb_q[sel]   <= dz ? rgv_pkg::T_HI : rgv_pkg::sat32(bsum);
        down_q[sel] <= !dpos;
      end
      if (cmd_i.walk) begin
        nb_q[ax] <= rgv_pkg::sat32(64'(nb_ax) + 64'(inc_q[ax]));
        if (!leave) begin
          coord_q[ax] <= down_q[ax] ? coord_q[ax] - 4'd1 : coord_q[ax] + 4'd1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.walk || cmd_i.emit_miss) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      o_q[0] <= org_x_i;
      o_q[1] <= org_y_i;
      o_q[2] <= org_z_i;
      d_q[0] <= dir_x_i;
      d_q[1] <= dir_y_i;
      d_q[2] <= dir_z_i;
    end
    if (cmd_i.slab_wr) begin
      if (!cmd_i.side) begin
        if (dz || dpos) tmin_q[sel] <= slab_v0;
        else            tmax_q[sel] <= slab_v0;
      end else begin
        if (dz || dpos) tmax_q[sel] <= slab_v1;
        else            tmin_q[sel] <= slab_v1;
      end
    end
    if (cmd_i.tload) begin
      t0_q <= t0_w;
      t1_q <= t1_w;
    end
    if (cmd_i.mul) prod_q <= 64'(t0_q) * 64'(d_s);
    if (cmd_i.emit_miss) begin
      missed_q <= 1'b1;
      last_q   <= 1'b1;
      idx_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      texit_q  <= '0;
    end else if (cmd_i.walk) begin
      missed_q <= 1'b0;
      last_q   <= walk_last;
      idx_q    <= idx_w[11:0];
      cx_q     <= coord_q[0];
      cy_q     <= coord_q[1];
      cz_q     <= coord_q[2];
      texit_q  <= nb_ax;
    end
  end

  always_comb begin
    stat_o.dz        = dz;
    stat_o.wpos      = (w64 > 64'sd0);
    stat_o.div_done  = div_done;
    stat_o.miss      = (t0_q > t1_q);
    stat_o.out_free  = out_free;
    stat_o.walk_last = walk_last;
  end

  assign out_valid_o  = out_valid_q;
  assign missed_o     = missed_q;
  assign cell_index_o = idx_q;
  assign cell_x_o     = cx_q;
  assign cell_y_o     = cy_q;
  assign cell_z_o     = cz_q;
  assign t_exit_o     = texit_q;
  assign last_o       = last_q;

endmodule

// File: hdl/rgv_ctrl.sv
// ----------------------------------------------------------------------------
// rgv_ctrl
// Sequencer: slab divisions, per-axis setup, then one cell per free output slot.
// ----------------------------------------------------------------------------
module rgv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rgv_pkg::rgv_stat_t stat_i,
  output rgv_pkg::rgv_cmd_t  cmd_o
);

  rgv_pkg::rgv_state_e state_q, state_d;
  logic [1:0]          ax_q, ax_d;
  logic                side_q, side_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgv_pkg::S_IDLE;
      ax_q    <= '0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      side_q  <= side_d;
    end
  end

  always_comb begin
    logic adv;
    adv        = 1'b0;
    state_d    = state_q;
    ax_d       = ax_q;
    side_d     = side_q;
    cmd_o      = '0;
    cmd_o.axis = ax_q;
    cmd_o.side = side_q;
    case (state_q)
      rgv_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ax_d       = '0;
          side_d     = 1'b0;
          state_d    = rgv_pkg::S_SLAB;
        end
      end
      rgv_pkg::S_SLAB: begin
        if (stat_i.dz) begin
          cmd_o.slab_wr = 1'b1;
          adv           = 1'b1;
        end else begin
          cmd_o.slab_start = 1'b1;
          state_d          = rgv_pkg::S_SLAB_W;
        end
      end
      rgv_pkg::S_SLAB_W: begin
        if (stat_i.div_done) begin
          cmd_o.slab_wr = 1'b1;
          adv           = 1'b1;
        end
      end
      rgv_pkg::S_MINMAX: begin
        cmd_o.tload = 1'b1;
        state_d     = rgv_pkg::S_CHECK;
      end
      rgv_pkg::S_CHECK: begin
        if (!stat_i.miss) begin
          ax_d    = '0;
          state_d = rgv_pkg::S_INC;
        end else if (stat_i.out_free) begin
          cmd_o.emit_miss = 1'b1;
          state_d         = rgv_pkg::S_IDLE;
        end
      end
      rgv_pkg::S_INC: begin
        cmd_o.inc_start = 1'b1;
        state_d         = rgv_pkg::S_INC_W;
      end
      rgv_pkg::S_INC_W: begin
        if (stat_i.div_done) begin
          cmd_o.inc_wr = 1'b1;
          state_d      = rgv_pkg::S_MUL;
        end
      end
      rgv_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = rgv_pkg::S_CELL;
      end
      rgv_pkg::S_CELL: begin
        if (stat_i.wpos) begin
          cmd_o.cell_start = 1'b1;
          state_d          = rgv_pkg::S_CELL_W;
        end else begin
          // flat box axis: entry cell is 0
          cmd_o.cell_wr   = 1'b1;
          cmd_o.cell_zero = 1'b1;
          state_d         = rgv_pkg::S_BND;
        end
      end
      rgv_pkg::S_CELL_W: begin
        if (stat_i.div_done) begin
          cmd_o.cell_wr = 1'b1;
          state_d       = rgv_pkg::S_BND;
        end
      end
      rgv_pkg::S_BND: begin
        cmd_o.bnd_wr = 1'b1;
        if (ax_q == rgv_pkg::AX_LAST) begin
          ax_d    = '0;
          state_d = rgv_pkg::S_WALK;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = rgv_pkg::S_INC;
        end
      end
      rgv_pkg::S_WALK: begin
        if (stat_i.out_free) begin
          cmd_o.walk = 1'b1;
          if (stat_i.walk_last) state_d = rgv_pkg::S_IDLE;
        end
      end
      default: state_d = rgv_pkg::S_IDLE;
    endcase
    if (adv) begin
      if (side_q) begin
        side_d = 1'b0;
        if (ax_q == rgv_pkg::AX_LAST) begin
          ax_d    = '0;
          state_d = rgv_pkg::S_MINMAX;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = rgv_pkg::S_SLAB;
        end
      end else begin
        side_d  = 1'b1;
        state_d = rgv_pkg::S_SLAB;
      end
    end
  end

  assign in_stall_o = (state_q != rgv_pkg::S_IDLE);

endmodule

// File: hdl/ray_grid_voxel_traversal.sv
// ----------------------------------------------------------------------------
// ray_grid_voxel_traversal
// Walks a ray through a uniform 3D grid of up to 16 cells per axis.
// ----------------------------------------------------------------------------
// Input channel: one word is a ray (origin and direction, signed Q16.16).
// Output channel: one word per cell visited, or a single miss word; the final
// word of a ray has last set. Both channels use valid/stall.
// Config: box corners and grid size on the cfg write port, always ready;
// write only while no ray is in flight.
// Sequence: six slab divisions (a zero direction component skips its two),
// then per axis an increment and an entry-cell division (skipped on a flat
// box axis), all on one shared divider. After the slabs either a miss word
// is registered or the per-axis setup runs and the cell words follow, one
// cell word per cycle while the output is not stalled.
// One ray is worked at a time; the next is taken once the last word of the
// previous one sits in the output register.
// A stalled output word holds and the walk waits for the slot.
// Reset: box 0..1.0 on each axis, one cell per axis, no word pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_grid_voxel_traversal #(
  parameter int AXIS_CELLS_MAX = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] org_x_i,
  input  logic signed [31:0] org_y_i,
  input  logic signed [31:0] org_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               missed_o,
  output logic [11:0]        cell_index_o,
  output logic [3:0]         cell_x_o,
  output logic [3:0]         cell_y_o,
  output logic [3:0]         cell_z_o,
  output logic signed [31:0] t_exit_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  rgv_pkg::rgv_cmd_t  cmd;
  rgv_pkg::rgv_stat_t stat;
  logic               miss_clear;
  logic               emit_ok;

  assign cfg_ready_o = 1'b1;

  rgv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rgv_dp #(
    .AXIS_CELLS_MAX (AXIS_CELLS_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .org_x_i      (org_x_i),
    .org_y_i      (org_y_i),
    .org_z_i      (org_z_i),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .dir_z_i      (dir_z_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .missed_o     (missed_o),
    .cell_index_o (cell_index_o),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .cell_z_o     (cell_z_o),
    .t_exit_o     (t_exit_o),
    .last_o       (last_o)
  );

  assign miss_clear = last_o && (cell_index_o == 12'd0) && (t_exit_o == 32'sd0);
  assign emit_ok    = !(cmd.walk && cmd.emit_miss) && stat.out_free;

  // a miss word is always the only and last word, with empty cell fields
  `ASSERT_IMPL(a_miss_word, clk_i, rst_ni, out_valid_o && missed_o, miss_clear)
  // once a ray is taken the input side closes until its last word is issued
  `ASSERT_NEXT(a_take_closes, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // walk and miss never emit together, and only into a free output slot
  `ASSERT_IMPL(a_one_emit, clk_i, rst_ni, cmd.walk || cmd.emit_miss, emit_ok)

endmodule
